### hdl/sobel_gradient_magnitude_unit_assert.svh
// Assertion macros for the Sobel gradient magnitude unit
`ifndef SOBEL_GRADIENT_MAGNITUDE_UNIT_ASSERT_SVH
`define SOBEL_GRADIENT_MAGNITUDE_UNIT_ASSERT_SVH

// same-cycle implication
`define SGM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SGM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/sgm_pkg.sv
// Shared constants, types and helpers for the Sobel gradient magnitude unit
`timescale 1ns / 1ps
package sgm_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W   = 8;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int FW_W    = 11;
   localparam int FH_W    = 13;
   localparam int SUM_W   = PIX_W + 2;
   localparam int GRAD_W  = SUM_W + 1;
   localparam int SQ_W    = 2 * SUM_W;
   localparam int ACC_W   = SQ_W + 1;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
   localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);
   localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
   localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
   localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);
   localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);
   localparam logic [PIX_W-1:0] GRAD_SAT = {PIX_W{1'b1}};

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic read;
      logic calc;
      logic sq_x;
      logic sq_y;
      logic root;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic root_last;
      logic out_free;
   } stat_type;

   function automatic logic [FW_W-1:0] clamp_width(input logic [FW_W-1:0] v);
      logic [FW_W-1:0] r;
      r = v;
      if (v < FW_MIN) r = FW_MIN;
      else if (v > FW_MAX) r = FW_MAX;
      return r;
   endfunction

   function automatic logic [FH_W-1:0] clamp_height(input logic [FH_W-1:0] v);
      logic [FH_W-1:0] r;
      r = v;
      if (v < FH_MIN) r = FH_MIN;
      else if (v > FH_MAX) r = FH_MAX;
      return r;
   endfunction

endpackage

### hdl/sgm_ctrl.sv
// Sequencing state machine for the Sobel gradient magnitude unit
`timescale 1ns / 1ps
module sgm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sgm_pkg::stat_type stat,
   output sgm_pkg::cmd_type  cmd
);
   import sgm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = stat.emit ? ST_SQX : ST_IDLE;
         end
         ST_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root = 1'b1;
            if (stat.root_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### hdl/sgm_dpath.sv
// Line stores, window, Sobel sums, squares, square root unit and result register
`timescale 1ns / 1ps
module sgm_dpath (
   input  logic                        clock,
   input  logic                        reset,
   input  sgm_pkg::cmd_type            cmd,
   output sgm_pkg::stat_type           stat,
   input  logic                        restart,
   input  logic [sgm_pkg::FW_W-1:0]    frame_width,
   input  logic [sgm_pkg::FH_W-1:0]    frame_height,
   input  logic [sgm_pkg::PIX_W-1:0]   req_pixel,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic [sgm_pkg::PIX_W-1:0]   rsp_gradient,
   output logic [sgm_pkg::COL_W-1:0]   rsp_center_col,
   output logic [sgm_pkg::ROW_W-1:0]   rsp_center_row,
   output logic                        rsp_frame_last
);
   import sgm_pkg::*;

   logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
   logic [PIX_W-1:0] upper_rd_ff;
   logic [PIX_W-1:0] middle_rd_ff;

   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] win_ff [6];
   logic [PIX_W-1:0] win_in [6];

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W:0]   col_next;
   logic [ROW_W:0]   row_next;
   logic             col_wrap;
   logic             row_wrap;

   logic [COL_W-1:0] pend_col_ff;
   logic [ROW_W-1:0] pend_row_ff;
   logic             pend_last_ff;

   logic [SUM_W-1:0]        sum_r, sum_l, sum_t, sum_b;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic signed [GRAD_W-1:0] sq_op;
   logic [SQ_W-1:0]          sq_prod;

   logic [ACC_W-1:0] sq_ff;
   logic [ACC_W-1:0] v_ff, res_ff, bit_ff;
   logic [ACC_W:0]   trial;
   logic             take;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] grad_ff;
   logic [COL_W-1:0] out_col_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic             out_last_ff;

   // line stores
   always_ff @(posedge clock) begin
      if (cmd.calc) upper_mem[col_ff] <= middle_rd_ff;
      if (cmd.read) upper_rd_ff <= upper_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) middle_mem[col_ff] <= pix_ff;
      if (cmd.read) middle_rd_ff <= middle_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) pix_ff <= req_pixel;
   end

   // position counters
   assign col_next = {1'b0, col_ff} + 1'b1;
   assign row_next = {1'b0, row_ff} + 1'b1;
   assign col_wrap = col_next >= frame_width;
   assign row_wrap = {1'b0, row_next} >= {1'b0, frame_height};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (cmd.calc) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign stat.emit = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));

   // window shift
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_in[i] = win_ff[i+3];
      end
      win_in[3] = upper_rd_ff;
      win_in[4] = middle_rd_ff;
      win_in[5] = pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (cmd.calc) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= win_in[i];
      end
   end

   // Sobel sums
   assign sum_r = {2'b0, upper_rd_ff} + {1'b0, middle_rd_ff, 1'b0} + {2'b0, pix_ff};
   assign sum_l = {2'b0, win_ff[0]} + {1'b0, win_ff[1], 1'b0} + {2'b0, win_ff[2]};
   assign sum_t = {2'b0, win_ff[0]} + {1'b0, win_ff[3], 1'b0} + {2'b0, upper_rd_ff};
   assign sum_b = {2'b0, win_ff[2]} + {1'b0, win_ff[5], 1'b0} + {2'b0, pix_ff};

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         gx_ff        <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
         gy_ff        <= $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
         pend_col_ff  <= col_ff - 1'b1;
         pend_row_ff  <= row_ff - 1'b1;
         pend_last_ff <= col_wrap && row_wrap;
      end
   end

   // squares, one multiply per cycle
   assign sq_op   = cmd.sq_x ? gx_ff : gy_ff;
   assign sq_prod = SQ_W'(sq_op * sq_op);

   always_ff @(posedge clock) begin
      if (cmd.sq_x) sq_ff <= {1'b0, sq_prod};
   end

   // restoring square root, one result bit per cycle
   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign take  = {1'b0, v_ff} >= trial;
   assign stat.root_last = bit_ff[0];

   always_ff @(posedge clock) begin
      if (cmd.sq_y) begin
         v_ff   <= sq_ff + {1'b0, sq_prod};
         res_ff <= '0;
         bit_ff <= ACC_W'(1) << (ACC_W - 1);
      end else if (cmd.root) begin
         if (take) begin
            v_ff   <= v_ff - trial[ACC_W-1:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // result register
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         grad_ff     <= (|res_ff[ACC_W-1:PIX_W]) ? GRAD_SAT : res_ff[PIX_W-1:0];
         out_col_ff  <= pend_col_ff;
         out_row_ff  <= pend_row_ff;
         out_last_ff <= pend_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gradient   = grad_ff;
   assign rsp_center_col = out_col_ff;
   assign rsp_center_row = out_row_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

### hdl/sobel_gradient_magnitude_unit.sv
// Top level of the Sobel gradient magnitude unit: register port and assembly
//
// Pixels enter on req_valid/req_ready as 8-bit gray words in raster order.
// One result word leaves on rsp_valid/rsp_ready for each interior pixel:
// gradient magnitude saturated to 255, center column and row, and a flag on
// the last interior result of the frame. Border pixels give no word.
// Frame width (address 0) and height (address 4) are set through the APB
// port; writing either restarts the frame at row 0, column 0.
// A border pixel passes through the line store read and the Sobel sums only.
// An interior pixel passes from acceptance to rsp_valid through the line store
// read, Sobel sums, squaring of both gradients on one multiplier, the
// bit-serial square root unit and the result load; the next pixel is taken
// only once the control is back in idle, so one pixel is in flight at a time.
// The result register frees the datapath: the next pixel is taken while a
// result waits; a stalled receiver holds the unit only when a second result
// is ready to load. Reset clears the counters, window and control state and
// loads 640 by 480; the line stores are not cleared.
`timescale 1ns / 1ps
`include "sobel_gradient_magnitude_unit_assert.svh"
module sobel_gradient_magnitude_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sgm_pkg::PIX_W-1:0]     req_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sgm_pkg::PIX_W-1:0]     rsp_gradient,
   output logic [sgm_pkg::COL_W-1:0]     rsp_center_col,
   output logic [sgm_pkg::ROW_W-1:0]     rsp_center_row,
   output logic                          rsp_frame_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [sgm_pkg::PADDR_W-1:0]   paddr,
   input  logic [sgm_pkg::PDATA_W-1:0]   pwdata,
   output logic [sgm_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);
   import sgm_pkg::*;

   logic [FW_W-1:0] fw_ff, fw_in;
   logic [FH_W-1:0] fh_ff, fh_in;
   logic            csr_write;
   csr_index_type   csr_index;
   cmd_type         cmd;
   stat_type        stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = csr_index_type'(paddr[2]);

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  fw_in = pwdata[FW_W-1:0];
            CSR_FRAME_HEIGHT: fh_in = pwdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FW_RESET;
         fh_ff <= FH_RESET;
      end else begin
         fw_ff <= fw_in;
         fh_ff <= fh_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_FRAME_WIDTH:  prdata = PDATA_W'(fw_ff);
         CSR_FRAME_HEIGHT: prdata = PDATA_W'(fh_ff);
         default:          prdata = '0;
      endcase
   end

   sgm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sgm_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .restart        (csr_write),
      .frame_width    (clamp_width(fw_ff)),
      .frame_height   (clamp_height(fh_ff)),
      .req_pixel      (req_pixel),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_gradient   (rsp_gradient),
      .rsp_center_col (rsp_center_col),
      .rsp_center_row (rsp_center_row),
      .rsp_frame_last (rsp_frame_last)
   );

   `SGM_ASSERT_NEXT(a_one_word_in_flight, clock, reset, req_valid && req_ready, !req_ready, "second word taken while busy")
   `SGM_ASSERT_SAME(a_load_needs_room, clock, reset, cmd.load_out, stat.out_free, "result register overwritten")
   `SGM_ASSERT_NEXT(a_rsp_from_load, clock, reset, !rsp_valid && !cmd.load_out, !rsp_valid, "result word without load")

endmodule
